// File: sv/cau_pkg.sv
// package for the complex arithmetic unit
// holds operation and status codes and default parameter values; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: sv/complex_arith_unit.sv
// top level of the complex arithmetic unit: add, subtract, multiply, divide
// depends on cau_pkg, cau_mult and cau_div_step
//
// usage:
// - drive operation and the four operands and pulse start; busy is always low,
//   so a transaction is taken in every cycle that start is high
// - each transaction returns one result on res_re, res_im and status, marked
//   by done for exactly one cycle; the receiver cannot stall it
// - every operation goes through the same pipeline, whose length is set by the
//   divider, one restoring step per stage for each quotient bit; throughput is
//   one transaction per cycle
// - multiplies use two-stage split multipliers; five stages form products,
//   sums and the divider operands before the division stages
// - results out of the signed range saturate with status 2; a divide by
//   zero gives zero with status 1
// - reset clears all valid bits, so no result appears after reset until a
//   new transaction has gone through
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   operation,
	input  wire logic signed [DATA_WIDTH-1:0] a_re,
	input  wire logic signed [DATA_WIDTH-1:0] a_im,
	input  wire logic signed [DATA_WIDTH-1:0] b_re,
	input  wire logic signed [DATA_WIDTH-1:0] b_im,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      res_re,
	output logic signed [DATA_WIDTH-1:0]      res_im,
	output logic [1:0]                        status
);
	import cau_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * DW;
	localparam int S1W = PW + 1;
	localparam int SW  = PW + 2;
	localparam int RW  = PW + DW + F;

	localparam logic signed [SW-1:0] MAX_V = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] MIN_V = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [SW-1:0] BIAS  = SW'((64'd1 << F) - 64'd1);
	localparam logic [DW-1:0] HALF  = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAXDW = {1'b0, {(DW-1){1'b1}}};

	// saturate a wide signed value to the result width, flag in the top bit
	function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] x);
		logic [DW:0] r;
		if (x > MAX_V)
			r = {1'b1, MAXDW};
		else if (x < MIN_V)
			r = {1'b1, HALF};
		else
			r = {1'b0, x[DW-1:0]};
		return r;
	endfunction

	// divider output to signed result with saturation, flag in the top bit
	function automatic logic [DW:0] dq_fn(input logic [DW-1:0] q, input logic neg,
		input logic ovf);
		logic [DW:0] r;
		if (ovf || (!neg && q >= HALF) || (neg && q > HALF))
			r = {1'b1, (neg ? HALF : MAXDW)};
		else
			r = {1'b0, (neg ? DW'(-q) : q)};
		return r;
	endfunction

	assign busy = 1'b0;

	// product pipeline: two stages
	logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;

	cau_mult #(.DW(DW)) u_mul_rr (.clk(clk), .a(a_re), .b(b_re), .prod(p_rr));
	cau_mult #(.DW(DW)) u_mul_ii (.clk(clk), .a(a_im), .b(b_im), .prod(p_ii));
	cau_mult #(.DW(DW)) u_mul_ri (.clk(clk), .a(a_re), .b(b_im), .prod(p_ri));
	cau_mult #(.DW(DW)) u_mul_ir (.clk(clk), .a(a_im), .b(b_re), .prod(p_ir));
	cau_mult #(.DW(DW)) u_mul_br (.clk(clk), .a(b_re), .b(b_re), .prod(p_bb_r));
	cau_mult #(.DW(DW)) u_mul_bi (.clk(clk), .a(b_im), .b(b_im), .prod(p_bb_i));

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4;
	logic [1:0] op_s1, op_s2, op_s3, op_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: add and subtract with saturation
	logic signed [SW-1:0] as_re, as_im;
	logic [DW:0] as_re_sat, as_im_sat;
	logic [DW-1:0] re_s1, im_s1, re_s2, im_s2, re_s3, im_s3;
	logic [1:0]    st_s1, st_s2, st_s3;

	always_comb begin
		if (operation == OP_SUB) begin
			as_re = SW'(a_re) - SW'(b_re);
			as_im = SW'(a_im) - SW'(b_im);
		end else begin
			as_re = SW'(a_re) + SW'(b_re);
			as_im = SW'(a_im) + SW'(b_im);
		end
		as_re_sat = sat_fn(as_re);
		as_im_sat = sat_fn(as_im);
	end

	always_ff @(posedge clk) begin
		op_s1 <= operation;
		re_s1 <= as_re_sat[DW-1:0];
		im_s1 <= as_im_sat[DW-1:0];
		st_s1 <= (as_re_sat[DW] || as_im_sat[DW]) ? ST_SAT : ST_OK;
		op_s2 <= op_s1;
		re_s2 <= re_s1;
		im_s2 <= im_s1;
		st_s2 <= st_s1;
	end

	// stage 3: sums of products and the divisor
	logic signed [S1W-1:0] mre_s3, mim_s3, dre_s3, dim_s3;
	logic [PW-1:0] m_s3;

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		re_s3  <= re_s2;
		im_s3  <= im_s2;
		st_s3  <= st_s2;
		mre_s3 <= S1W'(p_rr) - S1W'(p_ii);
		mim_s3 <= S1W'(p_ri) + S1W'(p_ir);
		dre_s3 <= S1W'(p_rr) + S1W'(p_ii);
		dim_s3 <= S1W'(p_ir) - S1W'(p_ri);
		m_s3   <= PW'($unsigned(p_bb_r)) + PW'($unsigned(p_bb_i));
	end

	// stage 4: multiply result truncated toward zero, divider magnitudes
	logic signed [SW-1:0] mt_re, mt_im;
	logic [DW:0] mre_sat, mim_sat;
	logic signed [S1W-1:0] abs_re, abs_im;
	logic [DW-1:0] re_s4, im_s4;
	logic [1:0]    st_s4;
	logic [PW-1:0] mag_re_s4, mag_im_s4, m_s4;
	logic          neg_re_s4, neg_im_s4;

	always_comb begin
		mt_re   = (SW'(mre_s3) + (mre_s3[S1W-1] ? BIAS : SW'(0))) >>> F;
		mt_im   = (SW'(mim_s3) + (mim_s3[S1W-1] ? BIAS : SW'(0))) >>> F;
		mre_sat = sat_fn(mt_re);
		mim_sat = sat_fn(mt_im);
		abs_re  = dre_s3[S1W-1] ? -dre_s3 : dre_s3;
		abs_im  = dim_s3[S1W-1] ? -dim_s3 : dim_s3;
	end

	always_ff @(posedge clk) begin
		op_s4 <= op_s3;
		if (op_s3 == OP_MUL) begin
			re_s4 <= mre_sat[DW-1:0];
			im_s4 <= mim_sat[DW-1:0];
			st_s4 <= (mre_sat[DW] || mim_sat[DW]) ? ST_SAT : ST_OK;
		end else begin
			re_s4 <= re_s3;
			im_s4 <= im_s3;
			st_s4 <= st_s3;
		end
		mag_re_s4 <= abs_re[PW-1:0];
		mag_im_s4 <= abs_im[PW-1:0];
		neg_re_s4 <= dre_s3[S1W-1];
		neg_im_s4 <= dim_s3[S1W-1];
		m_s4      <= m_s3;
	end

	// stage 5: dividends, quotient overflow check, divide by zero
	logic [RW-1:0] n_re, n_im, m_top;

	assign n_re  = RW'(mag_re_s4) << F;
	assign n_im  = RW'(mag_im_s4) << F;
	assign m_top = RW'(m_s4) << DW;

	// division pipeline, element 0 is stage 5
	logic [RW-1:0] d_rem_re [0:DW];
	logic [RW-1:0] d_rem_im [0:DW];
	logic [PW-1:0] d_m      [0:DW];
	logic [DW-1:0] d_q_re   [0:DW];
	logic [DW-1:0] d_q_im   [0:DW];

	// side data carried alongside the division
	logic          c_v      [0:DW];
	logic [1:0]    c_op     [0:DW];
	logic [DW-1:0] c_re     [0:DW];
	logic [DW-1:0] c_im     [0:DW];
	logic [1:0]    c_st     [0:DW];
	logic          c_neg_re [0:DW];
	logic          c_neg_im [0:DW];
	logic          c_ovf_re [0:DW];
	logic          c_ovf_im [0:DW];
	logic          c_dz     [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			c_v[0] <= 1'b0;
		else
			c_v[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		d_rem_re[0] <= n_re;
		d_rem_im[0] <= n_im;
		d_m[0]      <= m_s4;
		d_q_re[0]   <= '0;
		d_q_im[0]   <= '0;
		c_op[0]     <= op_s4;
		c_re[0]     <= re_s4;
		c_im[0]     <= im_s4;
		c_st[0]     <= st_s4;
		c_neg_re[0] <= neg_re_s4;
		c_neg_im[0] <= neg_im_s4;
		c_ovf_re[0] <= n_re >= m_top;
		c_ovf_im[0] <= n_im >= m_top;
		c_dz[0]     <= m_s4 == '0;
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		cau_div_step #(
			.DW(DW), .RW(RW), .MW(PW), .SHIFT(DW - 1 - k)
		) u_step (
			.clk(clk),
			.rem_re(d_rem_re[k]), .rem_im(d_rem_im[k]), .m(d_m[k]),
			.q_re(d_q_re[k]), .q_im(d_q_im[k]),
			.nrem_re(d_rem_re[k+1]), .nrem_im(d_rem_im[k+1]), .nm(d_m[k+1]),
			.nq_re(d_q_re[k+1]), .nq_im(d_q_im[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c_v[k+1] <= 1'b0;
			else
				c_v[k+1] <= c_v[k];
		end

		always_ff @(posedge clk) begin
			c_op[k+1]     <= c_op[k];
			c_re[k+1]     <= c_re[k];
			c_im[k+1]     <= c_im[k];
			c_st[k+1]     <= c_st[k];
			c_neg_re[k+1] <= c_neg_re[k];
			c_neg_im[k+1] <= c_neg_im[k];
			c_ovf_re[k+1] <= c_ovf_re[k];
			c_ovf_im[k+1] <= c_ovf_im[k];
			c_dz[k+1]     <= c_dz[k];
		end
	end

	// final stage: quotient sign and saturation, operation select
	logic [DW:0] fq_re, fq_im;

	assign fq_re = dq_fn(d_q_re[DW], c_neg_re[DW], c_ovf_re[DW]);
	assign fq_im = dq_fn(d_q_im[DW], c_neg_im[DW], c_ovf_im[DW]);

	logic          done_q;
	logic [DW-1:0] res_re_q, res_im_q;
	logic [1:0]    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= c_v[DW];
	end

	always_ff @(posedge clk) begin
		if (c_op[DW] != OP_DIV) begin
			res_re_q <= c_re[DW];
			res_im_q <= c_im[DW];
			status_q <= c_st[DW];
		end else if (c_dz[DW]) begin
			res_re_q <= '0;
			res_im_q <= '0;
			status_q <= ST_DZ;
		end else begin
			res_re_q <= fq_re[DW-1:0];
			res_im_q <= fq_im[DW-1:0];
			status_q <= (fq_re[DW] || fq_im[DW]) ? ST_SAT : ST_OK;
		end
	end

	assign done   = done_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

`ifndef SYNTHESIS
	// no status code outside the defined set leaves the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_DZ || status == ST_SAT))
		else $error("undefined status code");

	// divide by zero always returns zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DZ) |-> (res_re == '0 && res_im == '0))
		else $error("divide by zero with nonzero result");

	// a result strobe needs a transaction in the last division stage in the cycle before
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(c_v[DW]))
		else $error("result strobe without a transaction");
`endif

endmodule

`default_nettype wire

// File: sv/cau_mult.sv
// two-stage pipelined signed multiplier, split into two partial products
// uses cau_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none

module cau_mult #(
	parameter int DW = cau_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic signed [DW-1:0] a,
	input  wire logic signed [DW-1:0] b,
	output logic signed [2*DW-1:0]    prod
);
	import cau_pkg::*;

	localparam int H   = DW / 2;
	localparam int HW  = DW - H;
	localparam int PW  = 2 * DW;
	localparam int LOW = DW + H + 1;
	localparam int HIW = DW + HW;

	logic        [H-1:0]     b_lo;
	logic signed [HW-1:0]    b_hi;
	logic signed [DW+H:0]    plo_s1;
	logic signed [DW+HW-1:0] phi_s1;
	logic signed [PW-1:0]    prod_s2;

	assign b_lo = b[H-1:0];
	assign b_hi = b[DW-1:H];

	// partial products against the low and high halves of b
	always_ff @(posedge clk) begin
		plo_s1 <= LOW'(a) * LOW'($signed({1'b0, b_lo}));
		phi_s1 <= HIW'(a) * HIW'(b_hi);
	end

	// recombine partial products
	always_ff @(posedge clk) begin
		prod_s2 <= (PW'(phi_s1) <<< H) + PW'(plo_s1);
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

// File: sv/cau_div_step.sv
// one restoring division step for the real and imaginary quotient lanes
// shared divisor travels with the data; no package dependencies beyond defaults
`timescale 1ns / 1ps
`default_nettype none

module cau_div_step #(
	parameter int DW    = cau_pkg::DATA_WIDTH_DEF,
	parameter int RW    = 4 * DW,
	parameter int MW    = 2 * DW,
	parameter int SHIFT = 0
) (
	input  wire logic          clk,
	input  wire logic [RW-1:0] rem_re,
	input  wire logic [RW-1:0] rem_im,
	input  wire logic [MW-1:0] m,
	input  wire logic [DW-1:0] q_re,
	input  wire logic [DW-1:0] q_im,
	output logic      [RW-1:0] nrem_re,
	output logic      [RW-1:0] nrem_im,
	output logic      [MW-1:0] nm,
	output logic      [DW-1:0] nq_re,
	output logic      [DW-1:0] nq_im
);
	import cau_pkg::*;

	logic [RW-1:0] trial;
	logic          ge_re, ge_im;

	// shifted divisor for this quotient bit
	assign trial = RW'(m) << SHIFT;
	assign ge_re = rem_re >= trial;
	assign ge_im = rem_im >= trial;

	// conditional subtract, one quotient bit per lane
	always_ff @(posedge clk) begin
		nrem_re <= ge_re ? rem_re - trial : rem_re;
		nrem_im <= ge_im ? rem_im - trial : rem_im;
		nm      <= m;
		nq_re   <= {q_re[DW-2:0], ge_re};
		nq_im   <= {q_im[DW-2:0], ge_im};
	end

endmodule

`default_nettype wire
